// File: sv/dcr_pkg.sv
// shared types and constants for the disk controller register file
package dcr_pkg;

	localparam int SectorsPerTrack  = 22;
	localparam int HeadsPerCylinder = 3;
	localparam int WordsPerSector   = 256;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_ACK   = 2'd3
	} op_t;

	// request and response beats
	typedef struct packed {
		op_t         operation;
		logic [4:0]  reg_offset;
		logic [7:0]  write_byte;
		logic [15:0] disk_word;
		logic        disk_ok;
		logic [15:0] memory_word;
		logic        memory_ok;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_byte;
		logic [17:0] mem_address;
		logic        mem_write;
		logic [15:0] mem_write_data;
		logic [22:0] disk_block;
		logic [7:0]  word_in_sector;
		logic        disk_write;
		logic [15:0] disk_write_data;
		logic        irq_pending;
		logic        busy_res;
	} rsp_t;

	// register word indexes
	localparam logic [3:0] REG_CS1  = 4'd0;
	localparam logic [3:0] REG_WC   = 4'd1;
	localparam logic [3:0] REG_BA   = 4'd2;
	localparam logic [3:0] REG_HS   = 4'd3;
	localparam logic [3:0] REG_CS2  = 4'd4;
	localparam logic [3:0] REG_DS   = 4'd5;
	localparam logic [3:0] REG_ER   = 4'd6;
	localparam logic [3:0] REG_M0   = 4'd7;
	localparam logic [3:0] REG_CYL  = 4'd8;
	localparam logic [3:0] REG_M1   = 4'd9;
	localparam logic [3:0] REG_M2   = 4'd10;
	localparam logic [3:0] REG_M3   = 4'd11;
	localparam logic [3:0] REG_M4   = 4'd14;
	localparam logic [3:0] REG_M5   = 4'd15;

	// configuration register indexes
	localparam logic CFG_SECTOR_ONE = 1'b0;
	localparam logic CFG_DISK_ATT   = 1'b1;

	localparam logic [15:0] CS2_RESET = 16'o000100;
	localparam logic [15:0] DS_RESET  = 16'o100701;
	localparam logic [15:0] BA_MASK   = 16'o177776;

	// register bits and error codes
	localparam logic [15:0] GO_BIT   = 16'o1;
	localparam logic [15:0] IE_BIT   = 16'o100;
	localparam logic [15:0] RDY_BIT  = 16'o200;
	localparam logic [15:0] CERR_BIT = 16'o100000;
	localparam logic [15:0] DS_MASK  = 16'o7;
	localparam logic [15:0] BAI_BIT  = 16'o20;
	localparam logic [15:0] SCLR_BIT = 16'o40;
	localparam logic [15:0] IR_BIT   = 16'o100;
	localparam logic [15:0] ERRS     = 16'o177400;
	localparam logic [15:0] PGE_BIT  = 16'o2000;
	localparam logic [15:0] NEM_BIT  = 16'o4000;
	localparam logic [15:0] NED_BIT  = 16'o10000;
	localparam logic [15:0] WCE_BIT  = 16'o40000;
	localparam logic [15:0] DLT_BIT  = 16'o100000;
	localparam logic [15:0] ILF_BIT  = 16'o1;
	localparam logic [15:0] NXM_BIT  = 16'o2;
	localparam logic [15:0] IDAE_BIT = 16'o2000;
	localparam logic [15:0] DRDY_BIT = 16'o200;

	// function codes (control_one bits 5:1, shifted)
	localparam logic [5:0] FN_READ_A  = 6'o20;
	localparam logic [5:0] FN_READ_B  = 6'o70;
	localparam logic [5:0] FN_WRITE_A = 6'o22;
	localparam logic [5:0] FN_WRITE_B = 6'o60;
	localparam logic [5:0] FN_CHECK   = 6'o30;
	localparam logic [5:0] FN_NOP_A   = 6'o24;
	localparam logic [5:0] FN_NOP_B   = 6'o26;
	localparam logic [5:0] FN_NOP_MAX = 6'o16;

	typedef enum logic [1:0] {
		XF_READ  = 2'd0,
		XF_WRITE = 2'd1,
		XF_CHECK = 2'd2
	} xfer_t;

endpackage

// File: sv/dcr_if.sv
// valid/ready channel carrying one payload beat
interface dcr_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: sv/disk_controller_registers_dma.sv
// disk controller register file with a one-word-per-tick transfer engine
//
//  channel  dir  payload
//  req      in   operation, reg_offset, write_byte, disk_word, disk_ok, memory_word, memory_ok
//  rsp      out  read_byte, mem_address, mem_write(_data), disk_block, word_in_sector,
//                disk_write(_data), irq_pending, busy_res
//  apb      in   sector_one_based (0x0), disk_attached (0x4)
//
// one beat per cycle while the response side does not stall: each request updates the register file and
// its response lands in a single output register
// a request is taken while the output register is empty or is being drained
// arst_n clears the register file, the configuration and the output valid flag to their reset values
// apb writes take effect at the access cycle; pready is tied high
module disk_controller_registers_dma #(
	parameter int SECTORS_PER_TRACK  = dcr_pkg::SectorsPerTrack,
	parameter int HEADS_PER_CYLINDER = dcr_pkg::HeadsPerCylinder,
	parameter int WORDS_PER_SECTOR   = dcr_pkg::WordsPerSector
) (
	input  logic        clk,
	input  logic        arst_n,
	dcr_if.sink         req,
	dcr_if.source       rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dcr_pkg::*;

	localparam logic [4:0] SPT = 5'(SECTORS_PER_TRACK);
	localparam logic [3:0] HPC = 4'(HEADS_PER_CYLINDER);
	localparam logic [7:0] WLAST = 8'(WORDS_PER_SECTOR - 1);

	// configuration
	logic sector_one_q, disk_att_q;
	// register file
	logic [15:0] cs1_q, wc_q, ba_q, hs_q, cs2_q, ds_q, er_q, cyl_q;
	logic [15:0] misc_q [6];
	logic        done_q, ie_q, irq_q;
	logic [7:0]  swp_q;

	logic [15:0] cs1_d, wc_d, ba_d, hs_d, cs2_d, ds_d, er_d, cyl_d;
	logic [15:0] misc_d [6];
	logic        done_d, ie_d, irq_d;
	logic [7:0]  swp_d;

	// output register
	logic        out_v_q;
	logic [7:0]  rb_q;
	logic [17:0] ma_q;
	logic        mw_q, dw_q, irqo_q, busy_q;
	logic [15:0] mwd_q, dwd_q;
	logic [22:0] blk_q;
	logic [7:0]  wis_q;

	logic [7:0]  rb_d;
	logic        mw_d, dw_d;
	logic [15:0] mwd_d, dwd_d;

	logic take;
	assign req.ready = !out_v_q || rsp.ready;
	assign take = req.valid && req.ready;

	// apb
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		case (paddr[2])
			CFG_SECTOR_ONE: prdata = {31'd0, sector_one_q};
			CFG_DISK_ATT:   prdata = {31'd0, disk_att_q};
			default:        prdata = '0;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_one_q <= 1'b0;
			disk_att_q   <= 1'b0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == CFG_SECTOR_ONE) sector_one_q <= pwdata[0];
			else                            disk_att_q   <= pwdata[0];
		end
	end

	// zero-based sector from a head/sector word
	function automatic logic [4:0] zsec(input logic [15:0] hs, input logic one);
		logic [4:0] s;
		s = hs[4:0];
		if (one) begin
			if (s == 5'd0) s = SPT;
			s = s - 5'd1;
		end
		return s;
	endfunction

	function automatic logic [22:0] blk_of(input logic [15:0] cyl, input logic [2:0] h,
	                                       input logic [4:0] s);
		logic [22:0] t;
		t = 23'(cyl) * 23'(HPC) + 23'(h);
		return t * 23'(SPT) + 23'(s);
	endfunction

	// view of register index for reads
	function automatic logic [15:0] rd(input logic [3:0] idx, input logic [15:0] c1,
		input logic [15:0] wc, input logic [15:0] ba, input logic [15:0] hs,
		input logic [15:0] c2, input logic [15:0] ds, input logic [15:0] er,
		input logic [15:0] cy, input logic [15:0] m0, input logic [15:0] m1,
		input logic [15:0] m2, input logic [15:0] m3, input logic [15:0] m4,
		input logic [15:0] m5, input logic dn, input logic ie);
		logic [15:0] v;
		case (idx)
			REG_CS1: begin
				v = c1 & ~(RDY_BIT | IE_BIT | CERR_BIT);
				v[7]  = dn;
				v[6]  = ie;
				v[15] = (er != 0) || ((c2 & ERRS) != 0);
			end
			REG_WC:  v = wc;
			REG_BA:  v = ba;
			REG_HS:  v = hs;
			REG_CS2: v = c2;
			REG_DS:  v = ds;
			REG_ER:  v = er;
			REG_M0:  v = m0;
			REG_CYL: v = cy;
			REG_M1:  v = m1;
			REG_M2:  v = m2;
			REG_M3:  v = m3;
			REG_M4:  v = m4;
			REG_M5:  v = m5;
			default: v = '0;
		endcase
		return v;
	endfunction

	logic [1:0]  op;
	logic [3:0]  idx;
	logic        hi;
	logic [7:0]  b;
	logic [15:0] rv, wv;
	logic [5:0]  fn;
	logic [4:0]  s0, s_n;
	logic [2:0]  h0;
	logic [3:0]  h_n;
	logic        addr_ok;
	logic [1:0]  ext;
	logic [16:0] ba_sum;
	xfer_t       mode;
	logic        is_xfer;

	assign op  = req.data.operation;
	assign idx = req.data.reg_offset[4:1];
	assign hi  = req.data.reg_offset[0];
	assign b   = req.data.write_byte;
	assign fn  = {cs1_q[5:1], 1'b0};
	assign s0  = zsec(hs_q, sector_one_q);
	assign h0  = hs_q[10:8];
	assign addr_ok = (s0 < SPT) && ({1'b0, h0} < HPC);
	assign ext = cs1_q[9:8];

	// next-state logic for one request
	always_comb begin
		cs1_d = cs1_q; wc_d = wc_q; ba_d = ba_q; hs_d = hs_q; cs2_d = cs2_q;
		ds_d = ds_q; er_d = er_q; cyl_d = cyl_q; misc_d = misc_q;
		done_d = done_q; ie_d = ie_q; irq_d = irq_q; swp_d = swp_q;
		rb_d = '0; mw_d = 1'b0; dw_d = 1'b0; mwd_d = '0; dwd_d = '0;
		rv = rd(idx, cs1_q, wc_q, ba_q, hs_q, cs2_q, ds_q, er_q, cyl_q, misc_q[0],
		        misc_q[1], misc_q[2], misc_q[3], misc_q[4], misc_q[5], done_q, ie_q);
		wv = hi ? {b, rv[7:0]} : {rv[15:8], b};
		mode = XF_READ; is_xfer = 1'b0;
		ba_sum = '0; s_n = '0; h_n = '0;
		case (op)
			OP_READ: rb_d = hi ? rv[15:8] : rv[7:0];
			OP_ACK:  irq_d = 1'b0;
			OP_WRITE: begin
				if (idx == REG_DS || idx == REG_ER || idx >= 4'd12) begin
				end else if (cs1_q[0] && idx != REG_CS1) begin
					cs2_d = cs2_q | PGE_BIT | IR_BIT;
				end else begin
					case (idx)
						REG_CS1: begin
							if (hi) begin
								if (b[7]) begin
									// controller clear
									wc_d = '0; ba_d = '0; hs_d = '0; cyl_d = '0;
									for (int i = 1; i < 6; i++) misc_d[i] = '0;
									er_d = '0;
									cs2_d = (cs2_q & DS_MASK) | IR_BIT;
									swp_d = '0;
									done_d = 1'b1;
									if (ie_q) irq_d = 1'b1;
									cs1_d[0] = 1'b0;
								end else begin
									cs1_d[9:8] = b[1:0];
									misc_d[1][1:0] = b[1:0];
								end
							end else begin
								cs1_d[6:1] = b[6:1];
								ie_d = b[6];
								if (!b[6]) irq_d = 1'b0;
								if (!ie_q && b[6] && b[7]) irq_d = 1'b1;
								if (b[0] && !cs1_q[0] && done_q) begin
									done_d = 1'b0;
									cs1_d[0] = 1'b1;
									er_d = '0;
									cs2_d = (cs2_q & (DS_MASK | BAI_BIT | SCLR_BIT)) | IR_BIT;
									ds_d[7] = 1'b0;
									swp_d = '0;
								end
							end
						end
						REG_WC:  wc_d = wv;
						REG_BA:  ba_d = wv & BA_MASK;
						REG_HS:  hs_d = wv;
						REG_CS2: begin
							if (!hi) begin
								cs2_d = (cs2_q & ~16'o67) | {8'd0, b & 8'o67};
								if (b[5]) begin
									// subsystem clear
									cs1_d = '0; wc_d = '0; ba_d = '0; hs_d = '0;
									cs2_d = CS2_RESET; ds_d = DS_RESET; er_d = '0;
									cyl_d = '0;
									for (int i = 0; i < 6; i++) misc_d[i] = '0;
									done_d = 1'b1; ie_d = 1'b0; irq_d = 1'b0;
									swp_d = '0;
								end
							end
						end
						REG_M0:  misc_d[0] = wv;
						REG_CYL: cyl_d = wv;
						REG_M1: begin
							misc_d[1] = wv;
							cs1_d[9:8] = wv[1:0];
						end
						REG_M2:  misc_d[2] = wv;
						REG_M3:  misc_d[3] = wv;
						default: ;
					endcase
				end
			end
			OP_TICK: begin
				if (cs1_q[0]) begin
					if (fn <= FN_NOP_MAX || fn == FN_NOP_A || fn == FN_NOP_B) begin
						is_xfer = 1'b0;
						cs1_d[0] = 1'b0; ds_d[7] = 1'b1; done_d = 1'b1;
						if (ie_q) irq_d = 1'b1;
					end else if (fn == FN_READ_A || fn == FN_READ_B) begin
						is_xfer = 1'b1; mode = XF_READ;
					end else if (fn == FN_WRITE_A || fn == FN_WRITE_B) begin
						is_xfer = 1'b1; mode = XF_WRITE;
					end else if (fn == FN_CHECK) begin
						is_xfer = 1'b1; mode = XF_CHECK;
					end else begin
						er_d = er_q | ILF_BIT; cs2_d = cs2_q | IR_BIT;
						cs1_d[0] = 1'b0; ds_d[7] = 1'b1; done_d = 1'b1;
						if (ie_q) irq_d = 1'b1;
					end
				end
				if (is_xfer) begin
					// default: finish the command
					cs1_d[0] = 1'b0; ds_d[7] = 1'b1; done_d = 1'b1;
					if (ie_q) irq_d = 1'b1;
					if ((cs2_q & DS_MASK) != 16'd0 || !disk_att_q) begin
						cs2_d = cs2_q | NED_BIT | IR_BIT;
					end else if (!wc_q[15]) begin
					end else begin
						misc_d[1][1:0] = ext;
						if (!addr_ok) begin
							er_d = er_q | IDAE_BIT; cs2_d = cs2_q | IR_BIT;
						end else if (!req.data.disk_ok) begin
							cs2_d = cs2_q | DLT_BIT | IR_BIT;
						end else if (!req.data.memory_ok) begin
							cs2_d = cs2_q | NEM_BIT | IR_BIT;
							er_d = er_q | NXM_BIT;
						end else if (mode == XF_CHECK &&
						             req.data.memory_word != req.data.disk_word) begin
							cs2_d = cs2_q | WCE_BIT | IR_BIT;
						end else begin
							if (mode == XF_READ) begin
								mw_d = 1'b1; mwd_d = req.data.disk_word;
							end
							if (mode == XF_WRITE) begin
								dw_d = 1'b1; dwd_d = req.data.memory_word;
							end
							wc_d = wc_q + 16'd1;
							if (!cs2_q[4]) begin
								ba_sum = {1'b0, ba_q} + 17'd2;
								ba_d = ba_sum[15:0];
								if (ba_sum[15:0] < 16'd2) begin
									cs1_d[9:8] = ext + 2'd1;
									misc_d[1][1:0] = ext + 2'd1;
								end
							end
							if (swp_q >= WLAST) begin
								swp_d = '0;
								s_n = s0 + 5'd1; h_n = {1'b0, h0};
								if (s_n >= SPT) begin
									s_n = '0; h_n = {1'b0, h0} + 4'd1;
									if (h_n >= HPC) begin
										h_n = '0; cyl_d = cyl_q + 16'd1;
									end
								end
								if (sector_one_q) s_n = s_n + 5'd1;
								hs_d = {hs_q[15:11], h_n[2:0], hs_q[7:5], s_n};
							end else begin
								swp_d = swp_q + 8'd1;
							end
							if (wc_d != 16'd0) begin
								cs1_d[0] = cs1_q[0]; ds_d[7] = ds_q[7];
								done_d = done_q; irq_d = irq_q;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	// register file update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs1_q <= '0; wc_q <= '0; ba_q <= '0; hs_q <= '0;
			cs2_q <= CS2_RESET; ds_q <= DS_RESET; er_q <= '0; cyl_q <= '0;
			for (int i = 0; i < 6; i++) misc_q[i] <= '0;
			done_q <= 1'b1; ie_q <= 1'b0; irq_q <= 1'b0; swp_q <= '0;
		end else if (take) begin
			cs1_q <= cs1_d; wc_q <= wc_d; ba_q <= ba_d; hs_q <= hs_d;
			cs2_q <= cs2_d; ds_q <= ds_d; er_q <= er_d; cyl_q <= cyl_d;
			misc_q <= misc_d;
			done_q <= done_d; ie_q <= ie_d; irq_q <= irq_d; swp_q <= swp_d;
		end
	end

	// response view of the updated state
	logic [4:0]  s_r;
	logic        ok_r;
	logic [22:0] blk_r;
	assign s_r   = zsec(hs_d, sector_one_q);
	assign ok_r  = (s_r < SPT) && ({1'b0, hs_d[10:8]} < HPC);
	assign blk_r = blk_of(cyl_d, hs_d[10:8], s_r);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (take) out_v_q <= 1'b1;
		else if (rsp.ready) out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rb_q   <= rb_d;
			ma_q   <= {cs1_d[9:8], ba_d};
			mw_q   <= mw_d;  mwd_q <= mwd_d;
			dw_q   <= dw_d;  dwd_q <= dwd_d;
			blk_q  <= ok_r ? blk_r : '0;
			wis_q  <= swp_d;
			irqo_q <= irq_d;
			busy_q <= cs1_d[0];
		end
	end

	assign rsp.valid = out_v_q;
	always_comb begin
		rsp.data = '0;
		rsp.data.read_byte       = rb_q;
		rsp.data.mem_address     = ma_q;
		rsp.data.mem_write       = mw_q;
		rsp.data.mem_write_data  = mwd_q;
		rsp.data.disk_block      = blk_q;
		rsp.data.word_in_sector  = wis_q;
		rsp.data.disk_write      = dw_q;
		rsp.data.disk_write_data = dwd_q;
		rsp.data.irq_pending     = irqo_q;
		rsp.data.busy_res        = busy_q;
	end

`ifndef SYNTHESIS
	// strobes never both on in one beat
	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.data.mem_write && rsp.data.disk_write))
		else $error("both strobes set");
	// busy and done are exclusive in the register file
	a_go_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(cs1_q[0] && done_q))
		else $error("go with done");
	// a stalled response holds the output register
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(ma_q))
		else $error("response dropped");
`endif
endmodule

// File: verif/disk_controller_registers_dma_test.sv
// self-checking testbench for the disk controller register file and transfer engine
module disk_controller_registers_dma_test;
	import dcr_pkg::*;

	typedef struct {
		req_t       r;
		bit         typed;
		logic [7:0] rb;
	} row_t;

	localparam int          STALL_LEN = 300;
	localparam int          IDLE_LIMIT = 3000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;

	dcr_if #(.payload_t(req_t)) req_ch (clk);
	dcr_if #(.payload_t(rsp_t)) rsp_ch (clk);

	disk_controller_registers_dma uut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// model state
	logic [15:0] cs1, wcnt, badr, hsec, cs2, dstat, errs, cyl;
	logic [15:0] misc [6];
	bit          done_f, ie_f, irq_f;
	logic [7:0]  swpos;
	bit          cfg_one, cfg_disk;

	rsp_t       pending_rsp [$];
	bit         pending_typed [$];
	logic [7:0] pending_rb [$];
	int         fail_count = 0;
	int         sent = 0;
	int         idle_cycles = 0;
	bit         quiet = 0;
	bit         long_stall = 0;
	bit         paused = 0;

	function automatic void set_ext(logic [1:0] e);
		cs1[9:8] = e;
		misc[1][1:0] = e;
	endfunction

	function automatic void raise_done();
		done_f = 1;
		if (ie_f) irq_f = 1;
	endfunction

	function automatic void end_cmd();
		cs1 &= ~GO_BIT;
		dstat |= DRDY_BIT;
		raise_done();
	endfunction

	function automatic void cs2_err(logic [15:0] b);
		cs2 |= b | IR_BIT;
	endfunction

	function automatic void clear_all();
		cs1 = 0; wcnt = 0; badr = 0; hsec = 0;
		cs2 = CS2_RESET; dstat = DS_RESET; errs = 0; cyl = 0;
		foreach (misc[i]) misc[i] = 0;
		done_f = 1; ie_f = 0; irq_f = 0; swpos = 0;
	endfunction

	// zero-based sector and head, and whether they are in range
	function automatic bit geom(output int s, output int h);
		s = hsec[4:0];
		h = hsec[10:8];
		if (cfg_one) begin
			if (s == 0) s = SectorsPerTrack;
			s -= 1;
		end
		return s < SectorsPerTrack && h < HeadsPerCylinder;
	endfunction

	function automatic bit block_num(output logic [22:0] blk);
		int s, h;
		int unsigned b;
		blk = 0;
		if (!geom(s, h)) return 0;
		b = ((int'(cyl) * HeadsPerCylinder + h) * SectorsPerTrack + s);
		blk = b[22:0];
		return 1;
	endfunction

	function automatic void next_sector();
		int s, h;
		void'(geom(s, h));
		s++;
		if (s >= SectorsPerTrack) begin
			s = 0;
			h++;
			if (h >= HeadsPerCylinder) begin
				h = 0;
				cyl = cyl + 16'd1;
			end
		end
		if (cfg_one) s += 1;
		hsec = (hsec & ~16'o3437) | (16'(h & 7) << 8) | 16'(s & 31);
	endfunction

	function automatic logic [15:0] cs1_view();
		logic [15:0] v;
		v = cs1 & ~(RDY_BIT | IE_BIT | CERR_BIT);
		if (done_f) v |= RDY_BIT;
		if (ie_f) v |= IE_BIT;
		if (errs != 0 || (cs2 & ERRS) != 0) v |= CERR_BIT;
		return v;
	endfunction

	function automatic logic [15:0] reg_value(logic [3:0] idx);
		case (idx)
			REG_CS1: return cs1_view();
			REG_WC:  return wcnt;
			REG_BA:  return badr;
			REG_HS:  return hsec;
			REG_CS2: return cs2;
			REG_DS:  return dstat;
			REG_ER:  return errs;
			REG_M0:  return misc[0];
			REG_CYL: return cyl;
			REG_M1:  return misc[1];
			REG_M2:  return misc[2];
			REG_M3:  return misc[3];
			REG_M4:  return misc[4];
			REG_M5:  return misc[5];
			default: return 0;
		endcase
	endfunction

	function automatic void ctl_clear();
		wcnt = 0; badr = 0; hsec = 0; cyl = 0;
		for (int i = 1; i < 6; i++) misc[i] = 0;
		errs = 0;
		cs2 = (cs2 & DS_MASK) | IR_BIT;
		swpos = 0;
		done_f = 0;
		raise_done();
		cs1 &= ~GO_BIT;
	endfunction

	function automatic void bus_write(logic [4:0] off, logic [7:0] b);
		logic [3:0]  idx;
		logic [15:0] v;
		bit          old_go, old_ie;
		idx = off[4:1];
		if (idx == REG_DS || idx == REG_ER || idx >= 4'd12) return;
		v = reg_value(idx);
		if (off[0]) v[15:8] = b;
		else v[7:0] = b;
		if (cs1[0] && idx != REG_CS1) begin
			cs2_err(PGE_BIT);
			return;
		end
		case (idx)
			REG_CS1: begin
				if (off[0]) begin
					if (b[7]) ctl_clear();
					else set_ext(b[1:0]);
				end else begin
					old_go = cs1[0];
					old_ie = ie_f;
					cs1 = (cs1 & ~16'o176) | ({8'd0, b} & 16'o176);
					ie_f = b[6];
					if (!ie_f) irq_f = 0;
					if (!old_ie && ie_f && b[7]) irq_f = 1;
					if (b[0] && !old_go && done_f) begin
						done_f = 0;
						cs1 |= GO_BIT;
						errs = 0;
						cs2 = (cs2 & (DS_MASK | BAI_BIT | SCLR_BIT)) | IR_BIT;
						dstat &= ~DRDY_BIT;
						swpos = 0;
					end
				end
			end
			REG_WC:  wcnt = v;
			REG_BA:  badr = v & BA_MASK;
			REG_HS:  hsec = v;
			REG_CS2: begin
				if (!off[0]) begin
					cs2 = (cs2 & ~16'o67) | ({8'd0, b} & 16'o67);
					if (cs2 & SCLR_BIT) clear_all();
				end
			end
			REG_M0:  misc[0] = v;
			REG_CYL: cyl = v;
			REG_M1: begin
				misc[1] = v;
				set_ext(v[1:0]);
			end
			REG_M2:  misc[2] = v;
			REG_M3:  misc[3] = v;
			default: ;
		endcase
	endfunction

	// one word of a read, write or write-check transfer
	function automatic void move_word(xfer_t mode, req_t r, inout rsp_t o);
		logic [1:0]  ext;
		logic [22:0] blk;
		if ((cs2 & DS_MASK) != 0 || !cfg_disk) begin
			cs2_err(NED_BIT);
			end_cmd();
			return;
		end
		if (!wcnt[15]) begin
			end_cmd();
			return;
		end
		ext = cs1[9:8];
		set_ext(ext);
		if (!block_num(blk)) begin
			errs |= IDAE_BIT;
			cs2 |= IR_BIT;
			end_cmd();
			return;
		end
		if (!r.disk_ok) begin
			cs2_err(DLT_BIT);
			end_cmd();
			return;
		end
		if (!r.memory_ok) begin
			cs2_err(NEM_BIT);
			errs |= NXM_BIT;
			end_cmd();
			return;
		end
		if (mode == XF_READ) begin
			o.mem_write = 1;
			o.mem_write_data = r.disk_word;
		end else if (mode == XF_WRITE) begin
			o.disk_write = 1;
			o.disk_write_data = r.memory_word;
		end else if (r.memory_word != r.disk_word) begin
			cs2_err(WCE_BIT);
			end_cmd();
			return;
		end
		wcnt = wcnt + 16'd1;
		if (!(cs2 & BAI_BIT)) begin
			badr = badr + 16'd2;
			if (badr < 16'd2) set_ext(ext + 2'd1);
		end
		if (int'(swpos) + 1 >= WordsPerSector) begin
			swpos = 0;
			next_sector();
		end else begin
			swpos = swpos + 8'd1;
		end
		if (wcnt == 0) end_cmd();
	endfunction

	function automatic rsp_t predict_beat(req_t r);
		rsp_t        o;
		logic [15:0] v;
		logic [5:0]  fn;
		logic [22:0] blk;
		o = '0;
		case (r.operation)
			OP_READ: begin
				v = reg_value(r.reg_offset[4:1]);
				o.read_byte = r.reg_offset[0] ? v[15:8] : v[7:0];
			end
			OP_WRITE: bus_write(r.reg_offset, r.write_byte);
			OP_TICK: begin
				if (cs1[0]) begin
					fn = cs1[5:0] & 6'o76;
					if (fn <= FN_NOP_MAX || fn == FN_NOP_A || fn == FN_NOP_B) end_cmd();
					else if (fn == FN_READ_A || fn == FN_READ_B) move_word(XF_READ, r, o);
					else if (fn == FN_WRITE_A || fn == FN_WRITE_B) move_word(XF_WRITE, r, o);
					else if (fn == FN_CHECK) move_word(XF_CHECK, r, o);
					else begin
						errs |= ILF_BIT;
						cs2 |= IR_BIT;
						end_cmd();
					end
				end
			end
			default: irq_f = 0;
		endcase
		o.mem_address = {cs1[9:8], badr};
		if (block_num(blk)) o.disk_block = blk;
		o.word_in_sector = swpos;
		o.irq_pending = irq_f;
		o.busy_res = cs1[0];
		return o;
	endfunction

	task automatic check_field(string name, longint e, longint a);
		if (e != a) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			fail_count++;
		end
	endtask

	// clock
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// scoreboard: compare each result beat, then predict each accepted request beat
	always @(posedge clk) begin
		rsp_t e, a;
		bit   typed;
		logic [7:0] rb;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready || rsp_ch.valid && rsp_ch.ready)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (rsp_ch.valid && rsp_ch.ready) begin
				a = rsp_ch.data;
				if (pending_rsp.size() == 0) begin
					$error("result beat with nothing expected");
					fail_count++;
				end else begin
					e = pending_rsp.pop_front();
					typed = pending_typed.pop_front();
					rb = pending_rb.pop_front();
					if (typed) check_field("read_byte (directed)", rb, a.read_byte);
					check_field("read_byte", e.read_byte, a.read_byte);
					check_field("mem_address", e.mem_address, a.mem_address);
					check_field("mem_write", e.mem_write, a.mem_write);
					check_field("mem_write_data", e.mem_write_data, a.mem_write_data);
					check_field("disk_block", e.disk_block, a.disk_block);
					check_field("word_in_sector", e.word_in_sector, a.word_in_sector);
					check_field("disk_write", e.disk_write, a.disk_write);
					check_field("disk_write_data", e.disk_write_data, a.disk_write_data);
					check_field("irq_pending", e.irq_pending, a.irq_pending);
					check_field("busy_res", e.busy_res, a.busy_res);
				end
			end
			if (req_ch.valid && req_ch.ready)
				pending_rsp.push_back(predict_beat(req_ch.data));
		end
	end

	// watchdog on cycles with no beat moving
	initial begin
		forever begin
			@(posedge clk);
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// result receiver with random stalls and one long hold-off
	initial begin
		rsp_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (long_stall) begin
				rsp_ch.ready <= 0;
				repeat (STALL_LEN) @(posedge clk);
				long_stall = 0;
				rsp_ch.ready <= 1;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				rsp_ch.ready <= 0;
				repeat ($urandom_range(1, 10) - 1) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1;
			end
		end
	end

	// send one request beat, with an occasional random gap ahead of it
	task automatic send(req_t r, bit typed = 0, logic [7:0] rb = 0);
		bit hit;
		if (!quiet && $urandom_range(0, 6) == 0) begin
			req_ch.valid <= 0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		req_ch.valid <= 1;
		req_ch.data <= r;
		pending_typed.push_back(typed);
		pending_rb.push_back(rb);
		do begin
			@(negedge clk);
			hit = req_ch.ready;
			@(posedge clk);
		end while (!hit);
		sent++;
	endtask

	function automatic req_t mk(op_t op, logic [4:0] off, logic [7:0] b,
			logic [15:0] dw = 16'hffff, logic [15:0] mw = 16'hffff,
			logic dok = 1, logic mok = 1);
		req_t r;
		r.operation = op; r.reg_offset = off; r.write_byte = b;
		r.disk_word = dw; r.disk_ok = dok; r.memory_word = mw; r.memory_ok = mok;
		return r;
	endfunction

	function automatic req_t rand_word(op_t op, logic [4:0] off, logic [7:0] b);
		logic [15:0] dw;
		dw = 16'($urandom);
		return mk(op, off, b, dw, ($urandom_range(0, 19) == 0) ? 16'($urandom) : dw,
			$urandom_range(0, 40) != 0, $urandom_range(0, 40) != 0);
	endfunction

	task automatic drain(int extra);
		req_ch.valid <= 0;
		@(posedge clk);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic apb_write(logic idx, bit val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00}; pwdata <= {31'd0, val};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == CFG_SECTOR_ONE) cfg_one = val;
		else cfg_disk = val;
	endtask

	// one programmed transfer or command, with random register content
	task automatic run_command();
		int          n;
		logic [15:0] cnt;
		logic [5:0]  fn;
		logic [5:0]  fns [6] = '{FN_READ_A, FN_READ_B, FN_WRITE_A, FN_WRITE_B, FN_CHECK,
			FN_NOP_A};
		n = ($urandom_range(0, 30) == 0) ? $urandom_range(250, 520) : $urandom_range(1, 12);
		cnt = 16'(-n);
		if ($urandom_range(0, 15) == 0) cnt = 16'($urandom_range(0, 3));
		send(mk(OP_WRITE, 5'd16, ($urandom_range(0, 9) == 0) ? 8'hff :
			8'($urandom_range(0, 3))));
		send(mk(OP_WRITE, 5'd17, ($urandom_range(0, 9) == 0) ? 8'hff : 8'h00));
		send(mk(OP_WRITE, 5'd6, ($urandom_range(0, 9) == 0) ? 8'($urandom) :
			8'($urandom_range(0, 23))));
		send(mk(OP_WRITE, 5'd7, 8'($urandom_range(0, 3))));
		send(mk(OP_WRITE, 5'd2, cnt[7:0]));
		send(mk(OP_WRITE, 5'd3, cnt[15:8]));
		send(mk(OP_WRITE, 5'd4, 8'($urandom)));
		send(mk(OP_WRITE, 5'd5, 8'($urandom)));
		send(mk(OP_WRITE, 5'd8, ($urandom_range(0, 5) == 0) ?
			(($urandom_range(0, 1) != 0) ? BAI_BIT[7:0] : 8'd1) : 8'd0));
		if ($urandom_range(0, 3) == 0)
			send(mk(OP_WRITE, 5'd1, 8'($urandom_range(0, 3))));
		fn = ($urandom_range(0, 9) == 0) ? 6'($urandom) & 6'o76 : fns[$urandom_range(0, 5)];
		send(mk(OP_WRITE, 5'd0, {1'b0, $urandom_range(0, 1) == 1, fn} | 8'd1));
		for (int i = 0; i < n + 2; i++) begin
			if ($urandom_range(0, 25) == 0)
				send(mk(($urandom_range(0, 3) == 0) ? OP_ACK : OP_READ, 5'($urandom), 8'd0));
			else
				send(rand_word(OP_TICK, 5'($urandom), 8'($urandom)));
		end
	endtask

	row_t tbl [$];
	bit   cfg_set [4][2] = '{'{1, 1}, '{0, 1}, '{1, 0}, '{0, 1}};

	initial begin
		arst_n = 0;
		req_ch.valid = 0;
		req_ch.data = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		cfg_one = 0; cfg_disk = 0;
		clear_all();

		// directed rows: reset values, errors, clears, interrupt latch
		tbl.push_back('{mk(OP_READ, 5'd0, 8'd0), 1, 8'h80});
		tbl.push_back('{mk(OP_READ, 5'd8, 8'd0), 1, 8'h40});
		tbl.push_back('{mk(OP_READ, 5'd10, 8'd0), 1, 8'hc1});
		tbl.push_back('{mk(OP_READ, 5'd11, 8'd0), 1, 8'h81});
		tbl.push_back('{mk(OP_READ, 5'd31, 8'd0), 1, 8'h00});
		tbl.push_back('{mk(OP_WRITE, 5'd2, 8'hfe), 0, 8'd0});
		tbl.push_back('{mk(OP_WRITE, 5'd3, 8'hff), 0, 8'd0});
		tbl.push_back('{mk(OP_WRITE, 5'd0, 8'h11), 0, 8'd0});
		tbl.push_back('{mk(OP_TICK, 5'd0, 8'd0), 0, 8'd0});
		tbl.push_back('{mk(OP_READ, 5'd9, 8'd0), 1, 8'h10});
		tbl.push_back('{mk(OP_WRITE, 5'd0, 8'h35), 0, 8'd0});
		tbl.push_back('{mk(OP_TICK, 5'd0, 8'd0, 16'h0000, 16'h0000, 1'b0, 1'b0), 0, 8'd0});
		tbl.push_back('{mk(OP_READ, 5'd12, 8'd0), 1, 8'h01});
		tbl.push_back('{mk(OP_WRITE, 5'd0, 8'h01), 0, 8'd0});
		tbl.push_back('{mk(OP_WRITE, 5'd4, 8'h55), 0, 8'd0});
		tbl.push_back('{mk(OP_READ, 5'd9, 8'd0), 1, 8'h04});
		tbl.push_back('{mk(OP_TICK, 5'd0, 8'd0), 0, 8'd0});
		tbl.push_back('{mk(OP_WRITE, 5'd0, 8'hc0), 0, 8'd0});
		tbl.push_back('{mk(OP_ACK, 5'd0, 8'd0), 0, 8'd0});
		tbl.push_back('{mk(OP_WRITE, 5'd1, 8'h80), 0, 8'd0});
		tbl.push_back('{mk(OP_WRITE, 5'd8, 8'h20), 0, 8'd0});
		tbl.push_back('{mk(OP_READ, 5'd0, 8'd0), 1, 8'h80});
		tbl.push_back('{mk(OP_WRITE, 5'd1, 8'h03), 0, 8'd0});
		tbl.push_back('{mk(OP_WRITE, 5'd19, 8'hff), 0, 8'd0});
		tbl.push_back('{mk(OP_TICK, 5'd0, 8'd0, 16'h0000, 16'h0000), 0, 8'd0});

		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (tbl[i]) send(tbl[i].r, tbl[i].typed, tbl[i].rb);
		drain(4);

		// random phases over several configuration settings
		for (int ph = 0; ph < 4; ph++) begin
			apb_write(CFG_SECTOR_ONE, cfg_set[ph][0]);
			apb_write(CFG_DISK_ATT, cfg_set[ph][1]);
			if (ph == 1) long_stall = 1;
			while (sent < 25 + (ph + 1) * 235) begin
				if (ph == 2 && !paused && sent >= 25 + 2 * 235 + 100) begin
					drain(0);
					paused = 1;
				end
				if (ph == 3 && sent > 850) quiet = 1;
				if ($urandom_range(0, 6) == 0)
					send(mk(op_t'(2'($urandom)), 5'($urandom), 8'($urandom),
						16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom)));
				else
					run_command();
			end
			drain(4);
		end

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: filelist.f
sv/dcr_pkg.sv
sv/dcr_if.sv
sv/disk_controller_registers_dma.sv
verif/disk_controller_registers_dma_test.sv
